@@ hw/rtl/ldim_pkg.sv @@
// shared types, constants and helpers for the led dimmer block
`default_nettype none

package ldim_pkg;

    // default width of the potentiometer converter sample
    localparam int POT_BITS_DEFAULT = 8;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // field widths
    localparam int PERCENT_W  = 7;
    localparam int DEADBAND_W = 8;
    localparam int STEP_W     = 6;
    localparam int UART_NUM_W = 16;

    localparam logic [PERCENT_W-1:0] MAX_PERCENT = 7'd100;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POT_DEADBAND    = 2'd0,
        REG_BUTTON_ON_LEVEL = 2'd1,
        REG_POT_LEVEL_STEP  = 2'd2
    } t_reg_index;

    // reset values of the configuration registers
    localparam logic [DEADBAND_W-1:0] POT_DEADBAND_RST    = 8'd10;
    localparam logic [PERCENT_W-1:0]  BUTTON_ON_LEVEL_RST = 7'd100;
    localparam logic [STEP_W-1:0]     POT_LEVEL_STEP_RST  = 6'd25;

    // owner of the last input
    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_UART   = 2'd1,
        SRC_POT    = 2'd2,
        SRC_BUTTON = 2'd3
    } t_source;

    // decoded uart command kinds
    typedef enum logic [1:0] {
        UART_KIND_ON   = 2'd0,
        UART_KIND_NUM  = 2'd1,
        UART_KIND_TEXT = 2'd2
    } t_uart_kind;

    // clamp an 8 bit value to 100 percent
    function automatic logic [PERCENT_W-1:0] sat_percent(input logic [7:0] value);
        logic [PERCENT_W-1:0] result;
        if (value > {1'b0, MAX_PERCENT}) begin
            result = MAX_PERCENT;
        end else begin
            result = value[PERCENT_W-1:0];
        end
        return result;
    endfunction

endpackage : ldim_pkg

`default_nettype wire

@@ hw/rtl/ldim_if.sv @@
// valid/ready channel interfaces of the led dimmer block
`default_nettype none

interface ldim_in_if
    import ldim_pkg::*;
#(
    parameter int POT_BITS = POT_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic                         uart_event;
    logic [1:0]                   uart_kind;
    logic signed [UART_NUM_W-1:0] uart_number;
    logic                         button_event;
    logic                         pot_valid;
    logic [POT_BITS-1:0]          pot_sample;

    modport source (
        output valid, uart_event, uart_kind, uart_number, button_event, pot_valid,
               pot_sample,
        input  ready
    );
    modport sink (
        input  valid, uart_event, uart_kind, uart_number, button_event, pot_valid,
               pot_sample,
        output ready
    );
endinterface : ldim_in_if

interface ldim_out_if
    import ldim_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [PERCENT_W-1:0] duty_percent;
    logic                 led_on;
    logic [PERCENT_W-1:0] target_percent;
    logic [1:0]           active_source;

    modport source (
        output valid, duty_percent, led_on, target_percent, active_source,
        input  ready
    );
    modport sink (
        input  valid, duty_percent, led_on, target_percent, active_source,
        output ready
    );
endinterface : ldim_out_if

interface ldim_cfg_if
    import ldim_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface : ldim_cfg_if

`default_nettype wire

@@ hw/rtl/led_dimmer_source_priority_ramp_top.sv @@
// led dimmer with source priority and a one-step brightness ramp, top level
//
//  channel  | dir | modport | request carries
//  ---------+-----+---------+--------------------------------------------------
//  i_in     | in  | sink    | uart command, button press, pot sample (one tick)
//  o_out    | out | source  | duty, led state, target, active source
//  i_cfg    | in  | sink    | register index and write data
//
//  one tick per clock while the output is not stalled: a request lands in an
//  input register, then the tick is resolved and the result and state registers
//  are loaded together once the result register is free or being drained
//  the output register lets a new request enter while a result waits; a
//  stalled output holds the input register, which then holds i_in.ready low
//  i_rst_n (synchronous, active low) clears state and valids and returns the
//  config registers to their defaults
`default_nettype none

module led_dimmer_source_priority_ramp_top
    import ldim_pkg::*;
#(
    parameter int POT_BITS = POT_BITS_DEFAULT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ldim_in_if.sink    i_in,
    ldim_out_if.source o_out,
    ldim_cfg_if.sink   i_cfg
);

    // compare width for sample difference against the 8 bit deadband
    localparam int CMP_W = (POT_BITS > DEADBAND_W) ? POT_BITS : DEADBAND_W;

    // configuration registers
    logic [DEADBAND_W-1:0] r_pot_deadband;
    logic [PERCENT_W-1:0]  r_button_on_level;
    logic [STEP_W-1:0]     r_pot_level_step;

    // input register
    logic                         r_s1_valid;
    logic                         r_s1_uart_event;
    logic [1:0]                   r_s1_uart_kind;
    logic signed [UART_NUM_W-1:0] r_s1_uart_number;
    logic                         r_s1_button_event;
    logic                         r_s1_pot_valid;
    logic [POT_BITS-1:0]          r_s1_pot_sample;

    // tick state
    logic [PERCENT_W-1:0] r_applied;
    logic [PERCENT_W-1:0] r_goal;
    logic                 r_lamp;
    t_source              r_owner;
    logic [POT_BITS-1:0]  r_last_pot;

    // result register
    logic                 r_out_valid;
    logic [PERCENT_W-1:0] r_out_duty;
    logic                 r_out_led_on;
    logic [PERCENT_W-1:0] r_out_target;
    t_source              r_out_source;

    // next values
    logic [PERCENT_W-1:0] n_applied;
    logic [PERCENT_W-1:0] n_goal;
    logic                 n_lamp;
    t_source              n_owner;
    logic [POT_BITS-1:0]  n_last_pot;

    logic s1_advance;
    logic in_accept;

    // stage one moves on when the result register is free or being drained
    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in.valid && i_in.ready;

    // config is always taken
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = r_out_valid;
    assign o_out.duty_percent   = r_out_duty;
    assign o_out.led_on         = r_out_led_on;
    assign o_out.target_percent = r_out_target;
    assign o_out.active_source  = r_out_source;

    // configuration writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot_deadband    <= POT_DEADBAND_RST;
            r_button_on_level <= BUTTON_ON_LEVEL_RST;
            r_pot_level_step  <= POT_LEVEL_STEP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_POT_DEADBAND:    r_pot_deadband    <= i_cfg.data[DEADBAND_W-1:0];
                REG_BUTTON_ON_LEVEL: r_button_on_level <= i_cfg.data[PERCENT_W-1:0];
                REG_POT_LEVEL_STEP:  r_pot_level_step  <= i_cfg.data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_uart_event   <= i_in.uart_event;
            r_s1_uart_kind    <= i_in.uart_kind;
            r_s1_uart_number  <= i_in.uart_number;
            r_s1_button_event <= i_in.button_event;
            r_s1_pot_valid    <= i_in.pot_valid;
            r_s1_pot_sample   <= i_in.pot_sample;
        end
    end

    // resolve one tick: uart, then button, then pot, then one ramp step
    always_comb begin
        logic [POT_BITS-1:0]  diff;
        logic [CMP_W-1:0]     diff_ext;
        logic [CMP_W-1:0]     band_ext;
        logic [1:0]           level;
        logic [7:0]           product;
        logic [PERCENT_W-1:0] pot_goal;

        n_goal     = r_goal;
        n_lamp     = r_lamp;
        n_owner    = r_owner;
        n_last_pot = r_last_pot;

        if (r_s1_uart_event) begin
            case (r_s1_uart_kind)
                UART_KIND_ON: begin
                    n_owner = SRC_POT;
                end
                UART_KIND_NUM: begin
                    if (r_s1_uart_number == '0) begin
                        n_lamp = 1'b0;
                        n_goal = '0;
                    end else if (r_s1_uart_number >= 16'sd1 &&
                                 r_s1_uart_number <= 16'sd100) begin
                        n_lamp = 1'b1;
                        n_goal = r_s1_uart_number[PERCENT_W-1:0];
                    end
                    n_owner = SRC_UART;
                end
                default: begin
                    // unparsable text still claims ownership
                    n_owner = SRC_UART;
                end
            endcase
        end

        // button toggles between off and the configured on level
        if (r_s1_button_event) begin
            n_lamp  = !n_lamp;
            n_goal  = n_lamp ? sat_percent({1'b0, r_button_on_level}) : '0;
            n_owner = SRC_BUTTON;
        end

        // pot sample, gated by ownership and deadband
        diff     = (r_s1_pot_sample >= r_last_pot) ? r_s1_pot_sample - r_last_pot
                                                   : r_last_pot - r_s1_pot_sample;
        diff_ext = CMP_W'(diff);
        band_ext = CMP_W'(r_pot_deadband);
        // top two bits of the sample are the quantized level (0..3)
        level    = r_s1_pot_sample[POT_BITS-1 -: 2];
        product  = {6'd0, level} * {2'd0, r_pot_level_step};
        pot_goal = sat_percent(product);

        if (n_owner != SRC_UART && n_owner != SRC_BUTTON && r_s1_pot_valid &&
            diff_ext >= band_ext) begin
            n_last_pot = r_s1_pot_sample;
            n_goal     = pot_goal;
            n_lamp     = (pot_goal != '0);
            n_owner    = SRC_POT;
        end

        // one percent toward the target
        if (r_applied < n_goal) begin
            n_applied = r_applied + 7'd1;
        end else if (r_applied > n_goal) begin
            n_applied = r_applied - 7'd1;
        end else begin
            n_applied = r_applied;
        end
    end

    // state and result registers load on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_applied  <= '0;
            r_goal     <= '0;
            r_lamp     <= 1'b0;
            r_owner    <= SRC_NONE;
            r_last_pot <= '0;
        end else if (s1_advance) begin
            r_applied  <= n_applied;
            r_goal     <= n_goal;
            r_lamp     <= n_lamp;
            r_owner    <= n_owner;
            r_last_pot <= n_last_pot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_duty   <= n_applied;
            r_out_led_on <= n_lamp;
            r_out_target <= n_goal;
            r_out_source <= n_owner;
        end
    end

endmodule : led_dimmer_source_priority_ramp_top

`default_nettype wire
